// ===== sv/cst_pkg.sv =====
`timescale 1ns / 1ps

package cst_pkg;

  // request field widths
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 4;
  localparam int VALUE_W  = 16;
  localparam int TASK_W   = 4;

  // response field widths
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 5;

  // default sizing
  localparam int DEF_NUM_SEMS    = 16;
  localparam int DEF_QUEUE_DEPTH = 8;

  localparam logic signed [VALUE_W-1:0] COUNT_MAX = 16'sh7fff;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLOSE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_WAIT   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_SIGNAL = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } cst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } cst_stat_t;

endpackage

// ===== sv/cst_req_if.sv =====
`timescale 1ns / 1ps

interface cst_req_if import cst_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [INDEX_W-1:0]         sem_index;
  logic signed [VALUE_W-1:0]  initial_value;
  logic [TASK_W-1:0]          task_id;

  modport source (output valid, action, sem_index, initial_value, task_id,
                  input ready);
  modport sink   (input valid, action, sem_index, initial_value, task_id,
                  output ready);
endinterface

// ===== sv/cst_rsp_if.sv =====
`timescale 1ns / 1ps

interface cst_rsp_if import cst_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_given;
  logic                must_sleep;
  logic                woken_valid;
  logic [TASK_W-1:0]   woken_task;

  modport source (output valid, status, slot_given, must_sleep, woken_valid,
                  woken_task, input ready);
  modport sink   (input valid, status, slot_given, must_sleep, woken_valid,
                  woken_task, output ready);
endinterface

// ===== sv/cst_ctrl.sv =====
`timescale 1ns / 1ps

module cst_ctrl import cst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output cst_cmd_t  cmd,
  input  cst_stat_t stat
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && (state == S_IDLE);
  assign cmd.commit  = (state == S_COMMIT) && !stat.out_busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/cst_datapath.sv =====
`timescale 1ns / 1ps

module cst_datapath import cst_pkg::*; #(
  parameter int NUM_SEMS    = DEF_NUM_SEMS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cst_cmd_t                  cmd,
  output cst_stat_t                 stat,
  input  logic [ACTION_W-1:0]       action,
  input  logic [INDEX_W-1:0]        sem_index,
  input  logic signed [VALUE_W-1:0] initial_value,
  input  logic [TASK_W-1:0]         task_id,
  cst_rsp_if.source                 rsp
);

  localparam int SW        = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int PW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW        = $clog2(QUEUE_DEPTH + 1);
  localparam int TW        = FW + 1;
  localparam int MEM_DEPTH = NUM_SEMS * QUEUE_DEPTH;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // captured request
  logic [ACTION_W-1:0]       r_action;
  logic [INDEX_W-1:0]        r_index;
  logic signed [VALUE_W-1:0] r_value;
  logic [TASK_W-1:0]         r_task;

  // slot state
  logic [NUM_SEMS-1:0]        in_use;
  logic signed [VALUE_W-1:0]  count [NUM_SEMS];
  logic [PW-1:0]              head  [NUM_SEMS];
  logic [FW-1:0]              fill  [NUM_SEMS];

  // waiter queues, one QUEUE_DEPTH block per slot
  logic [TASK_W-1:0] waiters [MEM_DEPTH];
  logic [TASK_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;

  // output register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_sleep;
  logic                out_woken;
  logic [TASK_W-1:0]   out_task;

  // commit-cycle values
  logic [SW-1:0]             s;
  logic                      in_range;
  logic                      live;
  logic                      found;
  logic [SW-1:0]             free_idx;
  logic signed [VALUE_W-1:0] cnt;
  logic [PW-1:0]             hd;
  logic [FW-1:0]             fl;
  logic [TW-1:0]             tail_sum;
  logic [PW-1:0]             tail;
  logic [PW-1:0]             hd_inc;
  logic                      cnt_pos;
  logic                      q_room;

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_sleep;
  logic                res_woken;

  assign stat.out_busy = out_valid && !rsp.ready;

  assign s        = r_index[SW-1:0];
  assign in_range = (32'(r_index) < NUM_SEMS);
  assign live     = in_range && in_use[s];
  assign cnt      = count[s];
  assign hd       = head[s];
  assign fl       = fill[s];
  assign cnt_pos  = !cnt[VALUE_W-1] && (cnt != '0);
  assign q_room   = (32'(fl) < QUEUE_DEPTH);

  // tail = (head + fill) mod depth; sum stays below twice the depth
  assign tail_sum = TW'(hd) + TW'(fl);
  always_comb begin
    if (tail_sum >= TW'(QUEUE_DEPTH)) begin
      tail = PW'(tail_sum - TW'(QUEUE_DEPTH));
    end else begin
      tail = PW'(tail_sum);
    end
  end

  assign hd_inc = (32'(hd) == QUEUE_DEPTH - 1) ? '0 : hd + 1'b1;

  // lowest free slot
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        found    = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign rd_addr = AW'(s) * AW'(QUEUE_DEPTH) + AW'(hd);
  assign wr_addr = AW'(s) * AW'(QUEUE_DEPTH) + AW'(tail);
  assign wr_en   = cmd.commit && (r_action == ACT_WAIT) && live && !cnt_pos && q_room;

  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    res_sleep  = 1'b0;
    res_woken  = 1'b0;
    unique case (r_action)
      ACT_CREATE: begin
        res_slot = found ? SLOT_W'(free_idx) : SLOT_W'(NUM_SEMS);
        if (!found) res_status = ST_NO_FREE;
      end
      ACT_CLOSE: begin
      end
      ACT_WAIT: begin
        if (live && !cnt_pos) begin
          if (q_room) res_sleep = 1'b1;
          else        res_status = ST_QUEUE_FULL;
        end
      end
      ACT_SIGNAL: begin
        res_woken = live && (fl != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_action <= action;
      r_index  <= sem_index;
      r_value  <= initial_value;
      r_task   <= task_id;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= waiters[rd_addr];
    if (wr_en) waiters[wr_addr] <= r_task;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else if (cmd.commit) begin
      unique case (r_action)
        ACT_CREATE: begin
          if (found) begin
            in_use[free_idx] <= 1'b1;
            head[free_idx]   <= '0;
            fill[free_idx]   <= '0;
          end
        end
        ACT_CLOSE: begin
          if (in_range) in_use[s] <= 1'b0;
        end
        ACT_WAIT: begin
          if (live && !cnt_pos && q_room) fill[s] <= fl + 1'b1;
        end
        ACT_SIGNAL: begin
          if (live && (fl != '0)) begin
            head[s] <= hd_inc;
            fill[s] <= fl - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      priority if (r_action == ACT_CREATE && found) begin
        count[free_idx] <= r_value;
      end else if (r_action == ACT_WAIT && live && cnt_pos) begin
        count[s] <= cnt - 16'sd1;
      end else if (r_action == ACT_SIGNAL && live && fl == '0 && cnt != COUNT_MAX) begin
        count[s] <= cnt + 16'sd1;
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_sleep  <= res_sleep;
      out_woken  <= res_woken;
      out_task   <= res_woken ? rd_data : '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.slot_given  = out_slot;
  assign rsp.must_sleep  = out_sleep;
  assign rsp.woken_valid = out_woken;
  assign rsp.woken_task  = out_task;

endmodule

// ===== sv/counting_semaphore_table.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Payload
// req      in   req.valid/req.ready  action, sem_index, initial_value, task_id
// rsp      out  rsp.valid/rsp.ready  status, slot_given, must_sleep,
//                                    woken_valid, woken_task
//
// One request at a time, in the steps capture, waiter-memory read and commit
// when rsp is free; the registered read of the waiter memory costs the middle
// step. rsp.valid is loaded into the response register at the commit.
// A stalled rsp holds the commit; req.ready stays low until it lands.
// Synchronous reset clears slot use, queue pointers and both handshakes;
// counts and the waiter memory are not cleared.

module counting_semaphore_table import cst_pkg::*; #(
  parameter int NUM_SEMS    = DEF_NUM_SEMS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  cst_req_if.sink    req,
  cst_rsp_if.source  rsp
);

  cst_cmd_t  cmd;
  cst_stat_t stat;
  logic      ctl_ready;

  // controller sequences: accept -> read queue head -> commit + load response
  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ctl_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  assign req.ready = ctl_ready;

  // datapath: slot flags, counts, queue pointers, waiter memory, response reg
  cst_datapath #(
    .NUM_SEMS    (NUM_SEMS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (req.action),
    .sem_index     (req.sem_index),
    .initial_value (req.initial_value),
    .task_id       (req.task_id),
    .rsp           (rsp)
  );

  // one request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in flight");

  // a full queue never puts the caller to sleep nor wakes anyone
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_QUEUE_FULL |-> !rsp.must_sleep && !rsp.woken_valid)
    else $error("queue-full response with sleep or wake flag");

  // a wake is always an ok response with no slot reported
  a_wake_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.woken_valid |-> rsp.status == ST_OK && rsp.slot_given == '0
                                     && !rsp.must_sleep)
    else $error("wake response with bad status or slot");

  // a new response is loaded only by the commit of a request in flight
  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> !$past(req.ready))
    else $error("response loaded without a request in flight");

endmodule

// ===== bench/tb_counting_semaphore_table.sv =====
`timescale 1ns / 1ps

module tb_counting_semaphore_table;
  import cst_pkg::*;

  localparam int NUM_SEMS        = DEF_NUM_SEMS;
  localparam int QUEUE_DEPTH     = DEF_QUEUE_DEPTH;
  localparam int RANDOM_REQUESTS = 1000;
  // Longest legal quiet stretch is a long sender gap plus a long receiver
  // stall plus the pass through capture, queue read and commit.
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic [INDEX_W-1:0]        sem_index;
    logic signed [VALUE_W-1:0] initial_value;
    logic [TASK_W-1:0]         task_id;
  } sem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_given;
    logic                must_sleep;
    logic                woken_valid;
    logic [TASK_W-1:0]   woken_task;
  } sem_rsp_t;

  // one queued request plus the idle cycles the driver inserts ahead of it
  typedef struct {
    sem_req_t body;
    int       gap_before;
  } pending_t;

  logic clk;
  logic rst;

  cst_req_if req ();
  cst_rsp_if rsp ();

  counting_semaphore_table #(
    .NUM_SEMS   (NUM_SEMS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Shadow of the semaphore table. bit/int arrays start at zero, which is
  // the post-reset state of slot use and the queue pointers; counts and
  // waiter entries are written before they are ever read.
  // ---------------------------------------------------------------------
  bit                        slot_live   [NUM_SEMS];
  logic signed [VALUE_W-1:0] sem_count   [NUM_SEMS];
  logic [TASK_W-1:0]         waiter_fifo [NUM_SEMS][QUEUE_DEPTH];
  int unsigned               fifo_head   [NUM_SEMS];
  int unsigned               fifo_fill   [NUM_SEMS];

  sem_rsp_t answers_due[$];     // responses owed by the DUT, oldest first
  pending_t requests_todo[$];   // stimulus not yet presented
  bit       planned_live[NUM_SEMS]; // generator's view of slot use

  int  errors;
  int  idle_cycles;
  int  cycle_no;
  bit  req_taken;   // request accepted at the last rising edge
  bit  have_staged;
  int  gap_left;
  int  stall_left;
  pending_t staged;

  // Applies one request to the shadow table and returns the response it
  // must produce.
  function automatic sem_rsp_t sem_table_update(sem_req_t r);
    sem_rsp_t    a;
    int          s;
    int unsigned pos;
    bit          live;
    a    = '0;
    s    = r.sem_index;
    live = (s < NUM_SEMS) && slot_live[s];
    case (r.action)
      ACT_CREATE: begin
        // lowest free slot wins; a fresh slot starts with an empty queue
        s = 0;
        while (s < NUM_SEMS && slot_live[s]) s++;
        if (s < NUM_SEMS) begin
          slot_live[s] = 1'b1;
          sem_count[s] = r.initial_value;
          fifo_head[s] = 0;
          fifo_fill[s] = 0;
        end else begin
          a.status = ST_NO_FREE;
        end
        a.slot_given = SLOT_W'(s);
      end
      ACT_CLOSE: begin
        // waiters are left in place; a later create of this slot discards them
        if (s < NUM_SEMS) slot_live[s] = 1'b0;
      end
      ACT_WAIT: begin
        if (live) begin
          if (sem_count[s] > 0) begin
            sem_count[s] = sem_count[s] - 1;
          end else if (fifo_fill[s] < QUEUE_DEPTH) begin
            pos = (fifo_head[s] + fifo_fill[s]) % QUEUE_DEPTH;
            waiter_fifo[s][pos] = r.task_id;
            fifo_fill[s]++;
            a.must_sleep = 1'b1;
          end else begin
            a.status = ST_QUEUE_FULL;
          end
        end
      end
      ACT_SIGNAL: begin
        if (live) begin
          if (fifo_fill[s] > 0) begin
            // release only the oldest waiter, count untouched
            a.woken_valid = 1'b1;
            a.woken_task  = waiter_fifo[s][fifo_head[s]];
            fifo_head[s]  = (fifo_head[s] + 1) % QUEUE_DEPTH;
            fifo_fill[s]--;
          end else if (sem_count[s] < COUNT_MAX) begin
            sem_count[s] = sem_count[s] + 1;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic note_failure(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------
  task automatic queue_request(logic [ACTION_W-1:0] act, int idx, int value,
                               int tid, int gap);
    pending_t p;
    int       i;
    p.body.action        = act;
    p.body.sem_index     = INDEX_W'(idx);
    p.body.initial_value = VALUE_W'(value);
    p.body.task_id       = TASK_W'(tid);
    p.gap_before         = gap;
    requests_todo.push_back(p);
    // keep a rough map of live slots so later requests aim at them
    if (act == ACT_CREATE) begin
      i = 0;
      while (i < NUM_SEMS && planned_live[i]) i++;
      if (i < NUM_SEMS) planned_live[i] = 1'b1;
    end else if (act == ACT_CLOSE && idx < NUM_SEMS) begin
      planned_live[idx] = 1'b0;
    end
  endtask

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bias toward one hot slot so its queue fills, drains and overflows.
  function automatic int pick_slot();
    int used[$];
    int r;
    for (int i = 0; i < NUM_SEMS; i++) begin
      if (planned_live[i]) used.push_back(i);
    end
    r = $urandom_range(0, 99);
    if (used.size() != 0 && r < 40) return used[0];
    if (used.size() != 0 && r < 85) return used[$urandom_range(0, used.size() - 1)];
    return $urandom_range(0, NUM_SEMS - 1);
  endfunction

  // small counts keep waits blocking; extremes hit saturation and sign
  function automatic int pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return int'($urandom_range(0, 5)) - 2;
    if (r < 70) return 0;
    if (r < 78) return 32767 - int'($urandom_range(0, 1));
    if (r < 82) return -32768;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: changes on the falling edge, holds until accepted.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!(req.valid && !req_taken)) begin
      if (!have_staged && requests_todo.size() != 0) begin
        staged      = requests_todo.pop_front();
        have_staged = 1'b1;
        gap_left    = staged.gap_before;
      end
      if (have_staged && gap_left == 0) begin
        req.action        <= staged.body.action;
        req.sem_index     <= staged.body.sem_index;
        req.initial_value <= staged.body.initial_value;
        req.task_id       <= staged.body.task_id;
        req.valid         <= 1'b1;
        have_staged = 1'b0;
      end else begin
        req.valid <= 1'b0;
        if (have_staged) gap_left--;
      end
    end
  end

  // Response back-pressure: random stalls, with stall-free windows.
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp.ready <= 1'b1;
      if (((cycle_no / 250) % 4) != 1) stall_left = pick_gap();
    end
  end

  // Each accepted request updates the shadow table and queues its answer.
  always @(posedge clk) begin
    sem_req_t seen;
    if (!rst && req.valid && req.ready) begin
      seen.action        = req.action;
      seen.sem_index     = req.sem_index;
      seen.initial_value = req.initial_value;
      seen.task_id       = req.task_id;
      answers_due.push_back(sem_table_update(seen));
      req_taken <= 1'b1;
    end else begin
      req_taken <= 1'b0;
    end
  end

  // Response monitor: in-order compare against the oldest owed answer.
  always @(posedge clk) begin
    sem_rsp_t got;
    sem_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got.status      = rsp.status;
      got.slot_given  = rsp.slot_given;
      got.must_sleep  = rsp.must_sleep;
      got.woken_valid = rsp.woken_valid;
      got.woken_task  = rsp.woken_task;
      if (answers_due.size() == 0) begin
        note_failure($sformatf("%0t: response with none pending: st=%0d slot=%0d %s",
                               $time, got.status, got.slot_given,
                               $sformatf("sleep=%0b wv=%0b wt=%0d", got.must_sleep,
                                         got.woken_valid, got.woken_task)));
      end else begin
        want = answers_due.pop_front();
        if (got !== want) begin
          note_failure($sformatf(
            "%0t: mismatch exp st=%0d slot=%0d sleep=%0b wv=%0b wt=%0d got %s",
            $time, want.status, want.slot_given, want.must_sleep,
            want.woken_valid, want.woken_task,
            $sformatf("st=%0d slot=%0d sleep=%0b wv=%0b wt=%0d", got.status,
                      got.slot_given, got.must_sleep, got.woken_valid,
                      got.woken_task)));
        end
      end
    end
  end

  // Watchdog: any stretch with no handshake on either side this long is a hang.
  always @(posedge clk) begin
    cycle_no++;
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_counting_semaphore_table: errors");
      $finish;
    end
  end

  initial begin
    int                  n;
    int                  r;
    bit                  filling;
    bit                  steady;
    logic [ACTION_W-1:0] act;

    rst               = 1'b1;
    req.valid         = 1'b0;
    req.action        = ACT_CREATE;
    req.sem_index     = '0;
    req.initial_value = '0;
    req.task_id       = '0;
    rsp.ready         = 1'b0;

    // --- directed part ---
    queue_request(ACT_CREATE, 0, 32767, 0, 0);   // slot 0 at the count ceiling
    queue_request(ACT_SIGNAL, 0, 0, 0, 0);       // saturates, stays 32767
    queue_request(ACT_WAIT,   0, 0, 3, 0);       // takes one unit
    queue_request(ACT_CREATE, 0, -32768, 0, 0);  // slot 1, most negative count
    queue_request(ACT_WAIT,   1, 0, 15, 0);      // blocks
    queue_request(ACT_WAIT,   1, 0, 0, 1);       // blocks behind task 15
    queue_request(ACT_SIGNAL, 1, 0, 0, 0);       // releases task 15 only
    queue_request(ACT_CLOSE,  1, 0, 0, 0);       // close with a waiter queued
    queue_request(ACT_CREATE, 0, 0, 0, 0);       // reuses slot 1, queue emptied
    queue_request(ACT_SIGNAL, 1, 0, 0, 0);       // nobody waits: count to 1
    queue_request(ACT_WAIT,   1, 0, 0, 0);       // count back to 0
    for (int t = 1; t <= QUEUE_DEPTH + 1; t++) begin
      queue_request(ACT_WAIT, 1, 0, t, 0);       // fills the queue, then full
    end
    queue_request(ACT_SIGNAL, 1, 0, 0, 0);       // oldest is task 1
    queue_request(ACT_WAIT,   2, 0, 7, 0);       // free slot: no effect
    queue_request(ACT_SIGNAL, 15, 0, 0, 2);      // free slot: no effect
    queue_request(ACT_CLOSE,  5, 0, 0, 0);       // close of a free slot

    // --- random part: alternating fill and drain phases ---
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      filling = ((n / 120) % 2) == 0;
      steady  = ((n / 60) % 5) == 4;
      r       = $urandom_range(0, 99);
      if (filling) begin
        act = (r < 35) ? ACT_CREATE : (r < 40) ? ACT_CLOSE :
              (r < 72) ? ACT_WAIT : ACT_SIGNAL;
      end else begin
        act = (r < 8) ? ACT_CREATE : (r < 30) ? ACT_CLOSE :
              (r < 65) ? ACT_WAIT : ACT_SIGNAL;
      end
      queue_request(act, pick_slot(), pick_value(), $urandom_range(0, 15),
                    steady ? 0 : pick_gap());
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (requests_todo.size() != 0 || have_staged || req.valid) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb_counting_semaphore_table: clean");
    end else begin
      $display("tb_counting_semaphore_table: errors");
    end
    $finish;
  end

endmodule
